/* design/edm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_pkg: egg drop minimum trials, shared types and widths
// Fixed beat field widths and stream data widths.
// ----------------------------------------------------------------------------
package edm_pkg;

	localparam int FLOORS_W = 10;
	localparam int EGGS_W   = 5;
	localparam int DROPS_W  = 10;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	typedef logic [FLOORS_W-1:0] floors_t;
	typedef logic [EGGS_W-1:0]   eggs_t;
	typedef logic [DROPS_W-1:0]  drops_t;
	typedef logic [S_DATA_W-1:0] s_data_t;
	typedef logic [M_DATA_W-1:0] m_data_t;

endpackage

/* design/edm_reach_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edm_reach_step: shared reach update unit
// Adds two reach values plus one, saturates at the floor limit and compares
// the result against the floor count of the query.
// ----------------------------------------------------------------------------
module edm_reach_step #(
	parameter int MAX_FLOORS = 512
) (
	input  logic [$clog2(MAX_FLOORS+1)-1:0] old_reach,
	input  logic [$clog2(MAX_FLOORS+1)-1:0] prev_reach,
	input  logic [$clog2(MAX_FLOORS+1)-1:0] target,
	output logic [$clog2(MAX_FLOORS+1)-1:0] new_reach,
	output logic                            reached
);

	localparam int NW = $clog2(MAX_FLOORS + 1);

	logic [NW:0] sum;

	always_comb begin
		sum = {1'b0, old_reach} + {1'b0, prev_reach} + (NW+1)'(1);
		if (sum > (NW+1)'(MAX_FLOORS)) begin
			new_reach = NW'(MAX_FLOORS);
		end else begin
			new_reach = sum[NW-1:0];
		end
		reached = (new_reach >= target);
	end

endmodule

/* design/egg_drop_min_trials.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egg_drop_min_trials: minimum worst-case drop count for the egg puzzle
// Answers each floors/eggs beat with the fewest drops that always find the
// critical floor.
// ----------------------------------------------------------------------------
// The block finds the smallest drop count t whose reach with k eggs covers the
// floors. One adder walks the egg levels 1..k of a small reach memory, one
// level per cycle; one egg with MAX_FLOORS floors is the longest query. The
// input is not ready while a query runs; a result waits in the output register
// while the next query is taken. Eggs of zero count as one, eggs above MAX_EGGS
// and floors above MAX_FLOORS saturate.
module egg_drop_min_trials #(
	parameter int MAX_FLOORS = 512,
	parameter int MAX_EGGS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  edm_pkg::s_data_t  s_tdata,   // [9:0] floors, [14:10] eggs
	output logic              m_tvalid,
	input  logic              m_tready,
	output edm_pkg::m_data_t  m_tdata    // [9:0] min_drops
);

	import edm_pkg::*;

	localparam int NW = $clog2(MAX_FLOORS + 1);
	localparam int TW = $clog2(MAX_FLOORS + 2);
	localparam int KW = $clog2(MAX_EGGS + 1);
	localparam int AW = (MAX_EGGS > 1) ? $clog2(MAX_EGGS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t         state_q;
	logic [NW-1:0]  n_q;
	logic [AW-1:0]  klast_q;
	logic [AW-1:0]  ra_q;
	logic [TW-1:0]  tiss_q;
	logic           vld_s1;
	logic [AW-1:0]  ja_s1;
	logic [TW-1:0]  t_s1;
	logic           first_s1;
	logic [NW-1:0]  rd_s1;
	logic [NW-1:0]  prev_q;
	logic [TW-1:0]  res_q;
	logic           m_tvalid_q;
	drops_t         m_data_q;

	logic [NW-1:0]  reach_mem [MAX_EGGS];

	floors_t        floors;
	eggs_t          eggs;
	logic [NW-1:0]  n_sel;
	logic [KW-1:0]  k_sel;
	logic [NW-1:0]  old_reach;
	logic [NW-1:0]  new_reach;
	logic           reached;
	logic           hit_last;

	assign floors = s_tdata[FLOORS_W-1:0];
	assign eggs   = s_tdata[FLOORS_W+EGGS_W-1:FLOORS_W];

	always_comb begin
		if (32'(floors) > 32'(MAX_FLOORS)) begin
			n_sel = NW'(MAX_FLOORS);
		end else begin
			n_sel = NW'(floors);
		end
		if (eggs == '0) begin
			k_sel = KW'(1);
		end else if (32'(eggs) > 32'(MAX_EGGS)) begin
			k_sel = KW'(MAX_EGGS);
		end else begin
			k_sel = KW'(eggs);
		end
	end

	assign old_reach = first_s1 ? '0 : rd_s1;

	edm_reach_step #(
		.MAX_FLOORS(MAX_FLOORS)
	) u_step (
		.old_reach (old_reach),
		.prev_reach(prev_q),
		.target    (n_q),
		.new_reach (new_reach),
		.reached   (reached)
	);

	assign hit_last = vld_s1 && (ja_s1 == klast_q) && reached;

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && vld_s1) begin
			reach_mem[ja_s1] <= new_reach;
		end
		if (vld_s1 && ja_s1 == ra_q) begin
			rd_s1 <= new_reach;
		end else begin
			rd_s1 <= reach_mem[ra_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			klast_q    <= '0;
			ra_q       <= '0;
			tiss_q     <= '0;
			vld_s1     <= 1'b0;
			ja_s1      <= '0;
			t_s1       <= '0;
			first_s1   <= 1'b0;
			prev_q     <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (s_tvalid) begin
						n_q     <= n_sel;
						klast_q <= AW'(k_sel - KW'(1));
						ra_q    <= '0;
						tiss_q  <= TW'(1);
						prev_q  <= '0;
						res_q   <= '0;
						if (n_sel == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					vld_s1   <= !hit_last;
					ja_s1    <= ra_q;
					t_s1     <= tiss_q;
					first_s1 <= (tiss_q == TW'(1));
					if (ra_q == klast_q) begin
						ra_q   <= '0;
						tiss_q <= tiss_q + TW'(1);
					end else begin
						ra_q <= ra_q + AW'(1);
					end
					if (vld_s1) begin
						prev_q <= (ja_s1 == klast_q) ? '0 : old_reach;
					end
					if (hit_last) begin
						res_q   <= t_s1;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= DROPS_W'(res_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-DROPS_W){1'b0}}, m_data_q};

endmodule

/* tb/sv/egg_drop_min_trials_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egg_drop_min_trials_chk: result checker for the egg drop trial counter
// Watches both stream channels, works out the fewest drops for every accepted
// floors/eggs beat and compares each returned beat with the oldest answer due.
// ----------------------------------------------------------------------------
module egg_drop_min_trials_chk #(
	parameter int MAX_FLOORS = 512,
	parameter int MAX_EGGS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  edm_pkg::s_data_t s_tdata,   // [9:0] floors, [14:10] eggs
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  edm_pkg::m_data_t m_tdata,   // [9:0] min_drops
	output int               errors,
	output int               pending
);
	import edm_pkg::*;

	drops_t drops_due_q[$];

	// Grow the drop count until the floors that k eggs can cover reach n.
	function automatic drops_t min_drops_for(floors_t floors, eggs_t eggs);
		int n;
		int k;
		int drops;
		int reach[MAX_EGGS+1];
		int sum;
		n = floors;
		k = eggs;
		drops = 0;
		if (n > MAX_FLOORS)
			n = MAX_FLOORS;
		if (k == 0)
			k = 1;
		if (k > MAX_EGGS)
			k = MAX_EGGS;
		foreach (reach[j])
			reach[j] = 0;
		while (reach[k] < n) begin
			drops++;
			for (int j = k; j >= 1; j--) begin
				sum = reach[j] + reach[j-1] + 1;
				reach[j] = (sum > MAX_FLOORS) ? MAX_FLOORS : sum;
			end
		end
		return drops_t'(drops);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drops_t due;
		drops_t got;
		if (!arst_n) begin
			drops_due_q.delete();
			errors = 0;
		end else begin
			if (s_tvalid && s_tready)
				drops_due_q.push_back(min_drops_for(s_tdata[FLOORS_W-1:0],
					s_tdata[FLOORS_W +: EGGS_W]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[DROPS_W-1:0];
				if (drops_due_q.size() == 0) begin
					$error("min_drops: unexpected beat, expected none, actual %0d", got);
					errors++;
				end else begin
					due = drops_due_q.pop_front();
					if (got !== due) begin
						$error("min_drops mismatch: expected %0d, actual %0d", due, got);
						errors++;
					end
				end
			end
		end
		pending = drops_due_q.size();
	end

endmodule

/* tb/sv/egg_drop_min_trials_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egg_drop_min_trials_tb: stream test of the egg drop trial counter
// Sends directed corner queries and then random floors/eggs beats under three
// back-pressure mixes; a side checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module egg_drop_min_trials_tb;
	import edm_pkg::*;

	localparam int MAX_FLOORS   = 512;
	localparam int MAX_EGGS     = 16;
	localparam int RANDOM_BEATS = 1150;
	localparam int DRAIN_CYCLES = 600;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    s_tvalid = 1'b0;
	logic    s_tready;
	s_data_t s_tdata = '0;
	logic    m_tvalid;
	logic    m_tready = 1'b0;
	m_data_t m_tdata;
	int      errors;
	int      pending;
	int      tx_idle_pct = 16;
	int      rx_idle_pct = 54;

	egg_drop_min_trials #(
		.MAX_FLOORS(MAX_FLOORS),
		.MAX_EGGS  (MAX_EGGS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	egg_drop_min_trials_chk #(
		.MAX_FLOORS(MAX_FLOORS),
		.MAX_EGGS  (MAX_EGGS)
	) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Call at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_query(input floors_t floors, input eggs_t eggs);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= s_data_t'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, eggs, floors};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_random_query();
		floors_t floors;
		eggs_t   eggs;
		if ($urandom_range(9) == 0)
			floors = floors_t'($urandom_range(1023));
		else
			floors = floors_t'($urandom_range(80));
		if ($urandom_range(1) == 0)
			eggs = eggs_t'($urandom_range(31));
		else
			eggs = eggs_t'($urandom_range(1, 4));
		send_query(floors, eggs);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_query(10'd0, 5'd1);
		send_query(10'd0, 5'd0);
		send_query(10'd0, 5'd31);
		send_query(10'd1, 5'd1);
		send_query(10'd1, 5'd16);
		send_query(10'd2, 5'd2);
		send_query(10'd36, 5'd2);
		send_query(10'd100, 5'd2);
		send_query(10'd100, 5'd0);
		send_query(10'd100, 5'd3);
		send_query(10'd511, 5'd1);
		send_query(10'd512, 5'd1);
		send_query(10'd512, 5'd0);
		send_query(10'd512, 5'd16);
		send_query(10'd512, 5'd17);
		send_query(10'd513, 5'd2);
		send_query(10'd1023, 5'd1);
		send_query(10'd1023, 5'd31);
		send_query(10'd1023, 5'd10);
		send_query(10'd682, 5'd21);
		send_query(10'd341, 5'd15);
		send_query(10'd7, 5'd8);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 16;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 16;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_BEATS / 3; i++)
				send_random_query();
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
